### sv/ioapic_pkg.sv
// shared constants, types and index decode for the io apic register window
package ioapic_pkg;

  // redirection table size
  localparam int unsigned NUM_ENTRIES = 24;
  localparam int unsigned TBL_DEPTH   = 2 * NUM_ENTRIES;
  localparam int unsigned TBL_ADDR_W  = $clog2(TBL_DEPTH);

  // stream word widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_PAD_W   = M_TDATA_W - 33;

  // config port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 1'b1;
  localparam logic [3:0] DEVICE_ID_RST = 4'd0;
  localparam logic [7:0] VERSION_RST   = 8'd32;

  // access codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic WIN_INDEX = 1'b0;
  localparam logic WIN_DATA  = 1'b1;

  // register indexes
  localparam logic [7:0] IDX_ID      = 8'h00;
  localparam logic [7:0] IDX_VERSION = 8'h01;
  localparam logic [7:0] IDX_TABLE   = 8'h10;
  localparam logic [8:0] IDX_TBL_END = 9'(16 + 2 * NUM_ENTRIES);

  // stored bits of the entry words and the low word after reset
  localparam logic [31:0] LOW_KEEP  = 32'h0001_AFFF;
  localparam logic [31:0] HIGH_KEEP = 32'hFF00_0000;
  localparam logic [31:0] LOW_RST   = 32'h0001_0000;

  // entry count minus one, as shown in the version register
  localparam logic [7:0] VER_MAX_ENTRY = 8'(NUM_ENTRIES - 1);

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_ID,
    CLS_VERSION,
    CLS_TABLE
  } idx_class_t;

  function automatic idx_class_t classify(input logic [7:0] idx);
    idx_class_t cls;
    cls = CLS_NONE;
    if (idx == IDX_ID) begin
      cls = CLS_ID;
    end else if (idx == IDX_VERSION) begin
      cls = CLS_VERSION;
    end else if (idx >= IDX_TABLE && {1'b0, idx} < IDX_TBL_END) begin
      cls = CLS_TABLE;
    end
    return cls;
  endfunction

endpackage

### sv/io_apic_register_window_top.sv
// io apic register window: index-select and data window over a redirection table ram
//
//  channel  | dir | handshake          | word contents
//  ---------+-----+--------------------+---------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | command, window, write_data (one bus access)
//  m_*      | out | m_tvalid/m_tready  | read_data, index_valid (one reply per access)
//  cfg_*    | in  | cfg_we             | device_id (index 0), version_number (index 1)
//
// each access is split by the registered ram read: the accept cycle issues the table ram
// read, then the busy state, which can stall on the output, forms the reply and writes the
// entry back, so one access is in flight at a time.
// a finished reply waits in the output register; a new access is taken meanwhile
// and holds in the busy state until the output register frees up.
// rst is synchronous; table entries carry per-word valid bits cleared at reset,
// so no clearing pass is needed and an unwritten word reads its reset value.
module io_apic_register_window_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write port
  input  logic                                  cfg_we,
  input  logic [ioapic_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ioapic_pkg::CFG_DATA_W-1:0]     cfg_data,
  // access stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [ioapic_pkg::S_TDATA_W-1:0]      s_tdata,   // command, window, write_data[31:0], pad
  // reply stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ioapic_pkg::M_TDATA_W-1:0]      m_tdata    // read_data[31:0], index_valid, pad
);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t state;

  // config registers
  logic [3:0] device_id;
  logic [7:0] version_number;

  // architectural index
  logic [7:0] selected_index;

  // access held through the busy state
  logic                                cmd_q;
  logic                                win_q;
  logic [31:0]                         wdata_q;
  logic [ioapic_pkg::TBL_ADDR_W-1:0]   addr_q;
  ioapic_pkg::idx_class_t              cls_q;

  // per-word valid bits of the table ram
  logic [ioapic_pkg::TBL_DEPTH-1:0]    entry_valid;

  // output register
  logic                                out_valid;
  logic [31:0]                         read_data;
  logic                                index_valid;

  // input word fields
  logic        in_cmd;
  logic        in_win;
  logic [31:0] in_wdata;

  assign in_cmd   = s_tdata[0];
  assign in_win   = s_tdata[1];
  assign in_wdata = s_tdata[33:2];

  logic in_acc;
  logic finish;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  // the busy access retires when the output register is free or being drained
  assign finish   = (state == ST_BUSY) && (!out_valid || m_tready);

  // table address from the current index
  logic [7:0]                        tbl_off;
  logic [ioapic_pkg::TBL_ADDR_W-1:0] tbl_addr;

  assign tbl_off  = selected_index - ioapic_pkg::IDX_TABLE;
  assign tbl_addr = tbl_off[ioapic_pkg::TBL_ADDR_W-1:0];

  // table ram, low words at even addresses, high words at odd
  logic        ram_we;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  assign ram_we    = finish && (cmd_q == ioapic_pkg::CMD_WRITE) &&
                     (win_q == ioapic_pkg::WIN_DATA) && (cls_q == ioapic_pkg::CLS_TABLE);
  assign ram_wdata = addr_q[0] ? (wdata_q & ioapic_pkg::HIGH_KEEP)
                               : (wdata_q & ioapic_pkg::LOW_KEEP);

  ioapic_ram #(
    .WIDTH (32),
    .DEPTH (ioapic_pkg::TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (ram_wdata),
    .raddr (tbl_addr),
    .rdata (ram_rdata)
  );

  // reply value
  logic [31:0] tbl_word;
  logic [31:0] read_data_next;
  logic        index_valid_next;

  always_comb begin
    // an unwritten word shows its reset value
    if (entry_valid[addr_q]) begin
      tbl_word = ram_rdata;
    end else begin
      tbl_word = addr_q[0] ? 32'h0 : ioapic_pkg::LOW_RST;
    end

    read_data_next = 32'h0;
    if (cmd_q == ioapic_pkg::CMD_READ) begin
      if (win_q == ioapic_pkg::WIN_INDEX) begin
        read_data_next = {24'h0, selected_index};
      end else begin
        unique case (cls_q)
          ioapic_pkg::CLS_ID:      read_data_next = {4'h0, device_id, 24'h0};
          ioapic_pkg::CLS_VERSION: read_data_next = {8'h0, ioapic_pkg::VER_MAX_ENTRY,
                                                     8'h0, version_number};
          ioapic_pkg::CLS_TABLE:   read_data_next = tbl_word;
          default:                 read_data_next = 32'h0;
        endcase
      end
    end

    // index after the access: selected_index already took any index write
    index_valid_next = (ioapic_pkg::classify(selected_index) != ioapic_pkg::CLS_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      selected_index <= 8'h0;
      entry_valid    <= '0;
      device_id      <= ioapic_pkg::DEVICE_ID_RST;
      version_number <= ioapic_pkg::VERSION_RST;
    end else begin
      // config writes, expected only while no access is in flight
      if (cfg_we) begin
        unique case (cfg_index)
          ioapic_pkg::CFG_DEVICE_ID: device_id      <= cfg_data[3:0];
          ioapic_pkg::CFG_VERSION:   version_number <= cfg_data[7:0];
          default: ;
        endcase
      end

      // a drained reply empties the output register unless a retiring access refills it in the same cycle
      if (m_tvalid && m_tready && !finish) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state   <= ST_BUSY;
            cmd_q   <= in_cmd;
            win_q   <= in_win;
            wdata_q <= in_wdata;
            addr_q  <= tbl_addr;
            cls_q   <= ioapic_pkg::classify(selected_index);
            if (in_cmd == ioapic_pkg::CMD_WRITE && in_win == ioapic_pkg::WIN_INDEX) begin
              selected_index <= in_wdata[7:0];
            end
          end
        end
        ST_BUSY: begin
          if (finish) begin
            state       <= ST_IDLE;
            out_valid   <= 1'b1;
            read_data   <= read_data_next;
            index_valid <= index_valid_next;
            if (ram_we) begin
              entry_valid[addr_q] <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{ioapic_pkg::M_PAD_W{1'b0}}, index_valid, read_data};

endmodule

### sv/ioapic_ram.sv
// generic single-write, single-read ram with registered read data
module ioapic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ioapic_chk.sv
// port-level checker for the io apic register window, bound to the top level
module ioapic_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [ioapic_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ioapic_pkg::M_TDATA_W-1:0]  m_tdata
);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // a stalled reply word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("reply word changed while stalled");

  // one access in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("access accepted while another is in flight");

  // with the output empty, the reply is registered from the busy state that follows the accept
  a_reply_latency: assert property (@(posedge clk) disable iff (rst)
    s_acc && !m_tvalid |-> ##2 m_tvalid)
    else $error("reply missing two cycles after accept");

  // a write replies with zero data
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    s_acc && !m_tvalid && (s_tdata[0] == ioapic_pkg::CMD_WRITE) |-> ##2 (m_tdata[31:0] == 32'h0))
    else $error("write reply carries nonzero data");

  // an index write of the id register index is reported as a known index
  a_id_valid: assert property (@(posedge clk) disable iff (rst)
    s_acc && !m_tvalid && (s_tdata[0] == ioapic_pkg::CMD_WRITE) &&
    (s_tdata[1] == ioapic_pkg::WIN_INDEX) && (s_tdata[9:2] == ioapic_pkg::IDX_ID)
    |-> ##2 m_tdata[32])
    else $error("id index not flagged valid");

endmodule

bind io_apic_register_window_top ioapic_chk u_ioapic_chk (.*);
